@@ hw/rtl/ppgdc_pkg.sv @@
`default_nettype none

package ppgdc_pkg;

   localparam int BYTE_W    = 8;
   localparam int SAMPLE_W  = 24;
   localparam int PARTIAL_W = 40;
   localparam int POS_W     = 3;
   localparam int ALPHA_W   = 15;
   localparam int INTEG_W   = 46;
   localparam int AC_W      = 41;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 15'd31130;

   // Position of the last byte of a six-byte group.
   localparam logic [POS_W-1:0] LAST_POS = 3'd5;

   // Load strobes for the three integrator stages and the result register.
   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
      logic load_out;
   } stage_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/ppg_sample_dc_removal.sv @@
// PPG sample assembler with DC removal. Sensor FIFO bytes arrive one per
// transaction on the req_ channel and are grouped six at a time into two
// big-endian 24-bit samples, infrared first and then red. The sixth byte of a
// group updates one leaky integrator per channel, w = (x << FRAC_BITS) +
// ((alpha_gain * w_prev) >> 15), saturated at 2^46 - 1, and produces one rsp_
// transaction carrying both raw samples and the AC parts w - w_prev, which
// have FRAC_BITS fractional bits and saturate to the 41-bit signed range. The
// first five bytes of a group produce nothing. The block takes one byte per
// cycle unless a sixth byte waits as described below. The integrator runs as
// a three-stage pipeline (split leak product, recombine, add sample) followed
// by the result register, which raises rsp_valid. Only one group is in the
// integrator pipeline at a time, since each group needs the integrator value
// left by the previous one; a sixth byte therefore waits while the previous
// group has not yet reached the result register, which with six bytes per
// group only happens while rsp_stall holds a result back.
// The alpha_gain register (Q0.15, reset 31130, about 0.95) is written through
// csr_wr_en and csr_wr_data and must only change while no result is pending.
`default_nettype none

module ppg_sample_dc_removal #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic        [ppgdc_pkg::BYTE_W-1:0]  req_data_byte,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic             [ppgdc_pkg::SAMPLE_W-1:0] rsp_ir_raw,
   output logic             [ppgdc_pkg::SAMPLE_W-1:0] rsp_red_raw,
   output logic signed      [ppgdc_pkg::AC_W-1:0]    rsp_ir_ac,
   output logic signed      [ppgdc_pkg::AC_W-1:0]    rsp_red_ac,

   input  wire logic                                 csr_wr_en,
   input  wire logic        [ppgdc_pkg::ALPHA_W-1:0] csr_wr_data
);
   import ppgdc_pkg::*;

   logic [ALPHA_W-1:0]   alpha_ff, alpha_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [PARTIAL_W-1:0] partial_ff, partial_in;
   logic [SAMPLE_W-1:0]  ir_hold_ff, ir_hold_in;
   logic [SAMPLE_W-1:0]  red_hold_ff, red_hold_in;
   logic [SAMPLE_W-1:0]  rsp_ir_raw_ff, rsp_red_raw_ff;
   logic                 v1_ff, v1_in;
   logic                 v2_ff, v2_in;
   logic                 v3_ff, v3_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 pipe_busy;
   logic                 req_take;
   logic                 last_byte;
   logic                 out_ready;
   stage_ctl_type        ctl;

   // A group occupies the integrator pipeline from its sixth byte until it
   // lands in the result register.
   assign pipe_busy = v1_ff | v2_ff | v3_ff;
   assign last_byte = (pos_ff == LAST_POS);
   assign req_stall = last_byte & pipe_busy;
   assign req_take  = req_valid & ~req_stall;

   // The result register can take a new result when it is empty or its
   // current transaction completes in this cycle.
   assign out_ready = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      ctl.load_s1  = req_take & last_byte;
      ctl.load_s2  = v1_ff;
      ctl.load_s3  = v2_ff;
      ctl.load_out = v3_ff & out_ready;
   end

   // Byte assembly. The raw samples are held from the sixth byte until the
   // next group's sixth byte, which cannot enter before this group leaves.
   always_comb begin
      alpha_in    = csr_wr_en ? csr_wr_data : alpha_ff;
      pos_in      = pos_ff;
      partial_in  = partial_ff;
      ir_hold_in  = ir_hold_ff;
      red_hold_in = red_hold_ff;
      if (req_take) begin
         if (last_byte) begin
            pos_in      = '0;
            partial_in  = '0;
            ir_hold_in  = partial_ff[PARTIAL_W-1:PARTIAL_W-SAMPLE_W];
            red_hold_in = {partial_ff[SAMPLE_W-BYTE_W-1:0], req_data_byte};
         end else begin
            pos_in     = pos_ff + POS_W'(1);
            partial_in = {partial_ff[PARTIAL_W-BYTE_W-1:0], req_data_byte};
         end
      end
   end

   // Pipeline valids. Only one group is ever in flight, so stages one and
   // two always advance; stage three waits for the result register.
   always_comb begin
      v1_in        = ctl.load_s1;
      v2_in        = v1_ff;
      v3_in        = v2_ff | (v3_ff & ~out_ready);
      rsp_valid_in = ctl.load_out | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         pos_ff       <= '0;
         partial_ff   <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alpha_ff     <= alpha_in;
         pos_ff       <= pos_in;
         partial_ff   <= partial_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ir_hold_ff  <= ir_hold_in;
      red_hold_ff <= red_hold_in;
      if (ctl.load_out) begin
         rsp_ir_raw_ff  <= ir_hold_ff;
         rsp_red_raw_ff <= red_hold_ff;
      end
   end

   ppgdc_integ #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ir_integ (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .alpha_gain (alpha_ff),
      .raw        (ir_hold_ff),
      .ac         (rsp_ir_ac)
   );

   ppgdc_integ #(
      .FRAC_BITS (FRAC_BITS)
   ) u_red_integ (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .alpha_gain (alpha_ff),
      .raw        (red_hold_ff),
      .ac         (rsp_red_ac)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_ir_raw  = rsp_ir_raw_ff;
   assign rsp_red_raw = rsp_red_raw_ff;

   // At most one group is in the integrator pipeline.
   a_one_group: assert property (@(posedge clock) disable iff (reset)
      $onehot0({v1_ff, v2_ff, v3_ff}))
      else $error("more than one group in the integrator pipeline");

   // The byte position never goes past the last byte of a group.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("byte position out of range");

   // The first two stages never hold a group back.
   a_stage_flow: assert property (@(posedge clock) disable iff (reset)
      v1_ff |=> v2_ff ##1 (v3_ff || rsp_valid_ff))
      else $error("integrator pipeline lost a group");

   // A finished group that meets a free result register shows up there.
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !(rsp_valid_ff && rsp_stall)) |=> (rsp_valid_ff && !v3_ff))
      else $error("result register did not take a finished group");

endmodule

`default_nettype wire

@@ hw/rtl/ppgdc_integ.sv @@
`default_nettype none

module ppgdc_integ #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ppgdc_pkg::stage_ctl_type               ctl,
   input  wire logic        [ppgdc_pkg::ALPHA_W-1:0]   alpha_gain,
   input  wire logic        [ppgdc_pkg::SAMPLE_W-1:0]  raw,
   output logic signed      [ppgdc_pkg::AC_W-1:0]      ac
);
   import ppgdc_pkg::*;

   localparam int HALF_W  = INTEG_W / 2;
   localparam int UPPER_W = INTEG_W - HALF_W;
   localparam int PROD_W  = ALPHA_W + UPPER_W;
   localparam int FULL_W  = ALPHA_W + INTEG_W;
   localparam int SHIFT_W = SAMPLE_W + FRAC_BITS;
   localparam int WSUM_W  = ((SHIFT_W > INTEG_W) ? SHIFT_W : INTEG_W) + 1;
   localparam int DIFF_W  = INTEG_W + 2;

   logic        [INTEG_W-1:0] integ_ff, integ_in;
   logic        [PROD_W-1:0]  prod_lo_ff, prod_lo_in;
   logic        [PROD_W-1:0]  prod_hi_ff, prod_hi_in;
   logic        [FULL_W-1:0]  prod_full;
   logic        [INTEG_W-1:0] leak_ff, leak_in;
   logic        [WSUM_W-1:0]  w_ff, w_in;
   logic        [INTEG_W-1:0] w_sat;
   logic signed [DIFF_W-1:0]  diff;
   logic        [DIFF_W-AC_W:0] diff_top;
   logic signed [AC_W-1:0]    ac_ff, ac_in;

   // Stage 1: the leak product is split into two narrow partial products.
   assign prod_lo_in = PROD_W'(alpha_gain) * PROD_W'(integ_ff[HALF_W-1:0]);
   assign prod_hi_in = PROD_W'(alpha_gain) * PROD_W'(integ_ff[INTEG_W-1:HALF_W]);

   // Stage 2: recombine and drop the Q0.15 fraction, truncating.
   assign prod_full = (FULL_W'(prod_hi_ff) << HALF_W) + FULL_W'(prod_lo_ff);
   assign leak_in   = prod_full[FULL_W-1:ALPHA_W];

   // Stage 3: add the new sample scaled to the integrator's fixed point.
   assign w_in = (WSUM_W'(raw) << FRAC_BITS) + WSUM_W'(leak_ff);

   // Output stage: saturate the integrator, then the AC difference.
   always_comb begin
      if (w_ff[WSUM_W-1:INTEG_W] != '0) begin
         w_sat = '1;
      end else begin
         w_sat = w_ff[INTEG_W-1:0];
      end
      diff     = signed'({2'b00, w_sat}) - signed'({2'b00, integ_ff});
      diff_top = diff[DIFF_W-1:AC_W-1];
      if ((&diff_top) || !(|diff_top)) begin
         ac_in = diff[AC_W-1:0];
      end else if (diff[DIFF_W-1]) begin
         ac_in = {1'b1, {(AC_W-1){1'b0}}};
      end else begin
         ac_in = {1'b0, {(AC_W-1){1'b1}}};
      end
      integ_in = w_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (ctl.load_out) begin
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_s1) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
      if (ctl.load_s2) begin
         leak_ff <= leak_in;
      end
      if (ctl.load_s3) begin
         w_ff <= w_in;
      end
      if (ctl.load_out) begin
         ac_ff <= ac_in;
      end
   end

   assign ac = ac_ff;

endmodule

`default_nettype wire

@@ tb/ppg_sample_dc_removal_test.sv @@
module ppg_sample_dc_removal_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ppgdc_pkg::*;

   // The block is built with its default number of fractional bits.
   localparam int FRAC_BITS = 16;

   // A result passes through the integrator stages and the result register after
   // its sixth byte is accepted. This margin is allowed before a register write and at the end of the run.
   localparam int SETTLE_CYCLES = 8;

   // The receiver holds off this long once per marked phase, so that the input
   // side backs up behind a result that cannot leave.
   localparam int HOLD_OFF_CYCLES = 120;

   // Cycles in a row with no transaction on either channel before the run is
   // declared hung.
   localparam int IDLE_LIMIT = 3000;

   localparam logic [63:0] INTEG_MAX = (64'd1 << INTEG_W) - 64'd1;
   localparam longint      AC_MAX    = (longint'(1) << (AC_W - 1)) - 1;
   localparam longint      AC_MIN    = -(longint'(1) << (AC_W - 1));

   // One result transaction: both raw samples and both AC parts.
   typedef struct packed {
      logic        [SAMPLE_W-1:0] ir_raw;
      logic        [SAMPLE_W-1:0] red_raw;
      logic signed [AC_W-1:0]     ir_ac;
      logic signed [AC_W-1:0]     red_ac;
   } sample_pair_type;

   // A row of the directed table. Where typed is set, the result of the group
   // that this byte completes is given here rather than by the predictor.
   typedef struct packed {
      logic [BYTE_W-1:0] data_val;
      logic              typed;
      sample_pair_type   want;
   } table_row_type;

   // How the bytes of a random phase are drawn.
   typedef enum logic [1:0] {
      BYTES_RANDOM,
      BYTES_HIGH,
      BYTES_ZERO_HEAVY,
      BYTES_LOW
   } byte_style_type;

   // One random phase: the leak factor it runs with, its bytes, its length and its hold-off.
   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      byte_style_type     style;
      int                 count;
      logic               hold_off;
   } phase_type;

   // Receiver stall patterns, each kept for a random number of cycles.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_SPARSE,
      STALL_HEAVY,
      STALL_EVERY_THIRD
   } stall_pattern_type;

   // Directed part, run at the reset value of the leak factor. The first group
   // of zeros leaves both integrators at zero. The group of all ones then finds
   // a zero integrator, so its AC part is the full sample shifted up by the
   // fractional bits. The next zero group exercises the leak alone, and the
   // last group mixes bit patterns in both samples.
   localparam table_row_type DIRECTED_TABLE [24] = '{
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b1, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFF, 1'b1, '{24'hFF_FFFF, 24'hFF_FFFF, 41'h0FF_FFFF_0000, 41'h0FF_FFFF_0000}},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h12, 1'b0, '0},
      '{8'h34, 1'b0, '0},
      '{8'h56, 1'b0, '0},
      '{8'hA9, 1'b0, '0},
      '{8'hCB, 1'b0, '0},
      '{8'hED, 1'b0, '0}
   };

   // Random phases. The first runs the leak factor at its maximum with large
   // samples long enough to drive both integrators into saturation. The second
   // drops the leak factor to zero with mostly zero bytes, so the first group
   // sees the integrator fall from its maximum and the AC part clips at its
   // negative limit. Lengths are not all multiples of six, so some writes land
   // in the middle of a group.
   localparam phase_type PHASES [6] = '{
      '{15'd32767, BYTES_HIGH,       600, 1'b1},
      '{15'd0,     BYTES_ZERO_HEAVY, 124, 1'b0},
      '{15'd20000, BYTES_RANDOM,     301, 1'b1},
      '{15'd16384, BYTES_LOW,        200, 1'b0},
      '{15'd1,     BYTES_RANDOM,     151, 1'b0},
      '{15'd31130, BYTES_RANDOM,     250, 1'b0}
   };

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic        [BYTE_W-1:0]   req_data_byte;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic        [SAMPLE_W-1:0] rsp_ir_raw;
   logic        [SAMPLE_W-1:0] rsp_red_raw;
   logic signed [AC_W-1:0]     rsp_ir_ac;
   logic signed [AC_W-1:0]     rsp_red_ac;
   logic                       csr_wr_en;
   logic        [ALPHA_W-1:0]  csr_wr_data;

   // Predictor state: where we are in the six-byte group, the bytes gathered so
   // far, both integrators and the leak factor last written.
   logic [POS_W-1:0]     group_pos = '0;
   logic [PARTIAL_W-1:0] group_bytes = '0;
   logic [INTEG_W-1:0]   ir_integ = '0;
   logic [INTEG_W-1:0]   red_integ = '0;
   logic [ALPHA_W-1:0]   leak_factor = ALPHA_RESET;

   // Results predicted for accepted sixth bytes, oldest first.
   sample_pair_type pending_samples [$];

   int  mismatch_count = 0;
   int  burst_left = 0;
   int  idle_cycles = 0;
   bit  hold_off_request = 1'b0;

   ppg_sample_dc_removal #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data_byte(req_data_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_ir_raw   (rsp_ir_raw),
      .rsp_red_raw  (rsp_red_raw),
      .rsp_ir_ac    (rsp_ir_ac),
      .rsp_red_ac   (rsp_red_ac),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // One leaky integrator step. The leak product is truncated, the new value
   // clips at the integrator maximum, and the change from the old value clips
   // to the signed range of the AC output.
   function automatic void integrate_channel(input logic [SAMPLE_W-1:0] raw,
                                             input logic [ALPHA_W-1:0] alpha,
                                             inout logic [INTEG_W-1:0] integ,
                                             output logic signed [AC_W-1:0] ac);
      logic [63:0] leak;
      logic [63:0] sum;
      longint      diff;
      leak = (64'(alpha) * 64'(integ)) >> 15;
      sum = (64'(raw) << FRAC_BITS) + leak;
      if (sum > INTEG_MAX) begin
         sum = INTEG_MAX;
      end
      diff = longint'(sum) - longint'(64'(integ));
      if (diff > AC_MAX) begin
         diff = AC_MAX;
      end
      if (diff < AC_MIN) begin
         diff = AC_MIN;
      end
      integ = sum[INTEG_W-1:0];
      ac = diff[AC_W-1:0];
   endfunction

   // Takes one accepted byte into the group. Returns 1 with the result filled
   // in when the byte completes a group.
   function automatic bit absorb_byte(input logic [BYTE_W-1:0] data_val,
                                      output sample_pair_type res);
      logic [PARTIAL_W+BYTE_W-1:0] whole_group;
      res = '0;
      if (group_pos < LAST_POS) begin
         group_bytes = {group_bytes[PARTIAL_W-BYTE_W-1:0], data_val};
         group_pos = group_pos + POS_W'(1);
         return 1'b0;
      end
      whole_group = {group_bytes, data_val};
      res.ir_raw = whole_group[2*SAMPLE_W-1:SAMPLE_W];
      res.red_raw = whole_group[SAMPLE_W-1:0];
      group_pos = '0;
      group_bytes = '0;
      integrate_channel(res.ir_raw, leak_factor, ir_integ, res.ir_ac);
      integrate_channel(res.red_raw, leak_factor, red_integ, res.red_ac);
      return 1'b1;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_byte(input byte_style_type style);
      case (style)
         BYTES_HIGH: begin
            return ($urandom_range(0, 1) == 0) ? 8'hFF : BYTE_W'($urandom_range(0, 255));
         end
         BYTES_ZERO_HEAVY: begin
            return ($urandom_range(0, 3) != 0) ? 8'h00 : BYTE_W'($urandom_range(0, 255));
         end
         BYTES_LOW: begin
            return BYTE_W'($urandom_range(0, 15));
         end
         default: begin
            return BYTE_W'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // Offers one byte on the input channel and waits until it is accepted. The
   // sender works in bursts; when a burst is used up it may leave the channel
   // idle for a random gap before the next one starts. Bursts are sometimes
   // long, which gives stretches without any gaps on the input side.
   task automatic offer_byte(input logic [BYTE_W-1:0] data_val, input logic typed,
                             input sample_pair_type typed_res);
      int              gap_cycles;
      sample_pair_type res;
      if (burst_left == 0) begin
         gap_cycles = $urandom_range(0, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 24);
         if (gap_cycles != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap_cycles) @(posedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data_byte <= data_val;
      do @(posedge clock); while (req_stall);
      // The transaction completes at this edge; a sixth byte queues its result.
      if (absorb_byte(data_val, res)) begin
         pending_samples.push_back(typed ? typed_res : res);
      end
   endtask

   // Stops offering bytes and waits until every predicted result has been
   // taken, plus SETTLE_CYCLES, since the group in progress produces no
   // result of its own that could be waited for.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the leak factor while the block is idle and mirrors it in the
   // predictor.
   task automatic write_leak_factor(input logic [ALPHA_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      leak_factor = value;
   endtask

   task automatic flag_field(input string field, input logic [AC_W-1:0] want,
                             input logic [AC_W-1:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatch_count++;
   endtask

   // Result checker. Every transaction on the result channel is compared field
   // by field with the oldest predicted result. Outputs are sampled at the
   // rising edge, before the block updates them.
   always @(posedge clock) begin
      sample_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            $display("%0t: result with none expected, actual ir_raw %h red_raw %h",
                     $time, rsp_ir_raw, rsp_red_raw);
            mismatch_count++;
         end else begin
            want = pending_samples.pop_front();
            if (want.ir_raw !== rsp_ir_raw) begin
               flag_field("ir_raw", AC_W'(want.ir_raw), AC_W'(rsp_ir_raw));
            end
            if (want.red_raw !== rsp_red_raw) begin
               flag_field("red_raw", AC_W'(want.red_raw), AC_W'(rsp_red_raw));
            end
            if (want.ir_ac !== rsp_ir_ac) begin
               flag_field("ir_ac", want.ir_ac, rsp_ir_ac);
            end
            if (want.red_ac !== rsp_red_ac) begin
               flag_field("red_ac", want.red_ac, rsp_red_ac);
            end
         end
      end
   end

   // Watchdog. A run in which neither channel moves for too long has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver. It switches between stall patterns, each held for a random
   // number of cycles. When the stimulus asks for a hold-off, it raises the
   // stall for a long stretch counted here, while the sender keeps offering
   // bytes, so the integrator pipeline backs up and the input stalls.
   initial begin : receiver
      stall_pattern_type pattern;
      int                span;
      int                k;
      rsp_stall = 1'b0;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            pattern = stall_pattern_type'($urandom_range(0, 3));
            span = $urandom_range(10, 80);
            for (k = 0; k < span; k++) begin
               @(negedge clock);
               case (pattern)
                  STALL_NONE: begin
                     rsp_stall <= 1'b0;
                  end
                  STALL_SPARSE: begin
                     rsp_stall <= ($urandom_range(0, 4) == 0);
                  end
                  STALL_HEAVY: begin
                     rsp_stall <= ($urandom_range(0, 3) != 0);
                  end
                  default: begin
                     rsp_stall <= (k % 3 != 0);
                  end
               endcase
            end
         end
      end
   end

   // Stimulus. Reset is held first, the directed table runs at the reset value
   // of the leak factor, and then each random phase writes its own leak factor
   // before sending its bytes.
   initial begin : stimulus
      int row;
      int phase;
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < 24; row++) begin
         offer_byte(DIRECTED_TABLE[row].data_val, DIRECTED_TABLE[row].typed,
                    DIRECTED_TABLE[row].want);
      end

      for (phase = 0; phase < 6; phase++) begin
         write_leak_factor(PHASES[phase].alpha);
         if (PHASES[phase].hold_off) begin
            hold_off_request = 1'b1;
         end
         for (n = 0; n < PHASES[phase].count; n++) begin
            offer_byte(pick_byte(PHASES[phase].style), 1'b0, '0);
         end
      end

      // Every byte is in; wait for the last results, then allow SETTLE_CYCLES
      // for anything stray to show up.
      drain_results();
      if (mismatch_count == 0 && pending_samples.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
